### design/bayer_bilinear_demosaic_assert.svh
// Assertion macros shared by the demosaic RTL.
`ifndef BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define BBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### design/bbd_pkg.sv
// Package with types, constants and the neighbor tap table of the demosaic block.
`default_nettype none
package bbd_pkg;

    // Default store size.
    localparam int C_MAX_WIDTH  = 512;
    localparam int C_MAX_HEIGHT = 256;

    // Field and register widths.
    localparam int C_CFG_WIDTH_W  = 10;
    localparam int C_CFG_HEIGHT_W = 9;
    localparam int C_COL_W        = 9;
    localparam int C_ROW_W        = 8;
    localparam int C_PIX_W        = 8;
    localparam int C_STEP_W       = 4;
    localparam int C_MIN_SIZE     = 3;

    // Register reset values.
    localparam logic [C_CFG_WIDTH_W-1:0]  C_WIDTH_RESET  = 10'd316;
    localparam logic [C_CFG_HEIGHT_W-1:0] C_HEIGHT_RESET = 9'd208;

    // Number of neighbor fetches per read.
    localparam logic [C_STEP_W-1:0] C_TAPS_ALL   = 4'd9;
    localparam logic [C_STEP_W-1:0] C_TAPS_GREEN = 4'd5;

    // Action codes carried in tuser.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        G_CENTER,
        G_HORIZ,
        G_VERT,
        G_DIAG
    } t_tap_grp;

    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } t_off;

    typedef struct packed {
        t_off     dx;
        t_off     dy;
        t_tap_grp grp;
    } t_tap;

    // Neighbor order: center, left, right, up, down, then the four corners.
    function automatic t_tap tap_info(input logic [C_STEP_W-1:0] idx);
        t_tap t;
        t = '{dx: OFF_ZERO, dy: OFF_ZERO, grp: G_CENTER};
        case (idx)
            4'd0: t = '{dx: OFF_ZERO, dy: OFF_ZERO, grp: G_CENTER};
            4'd1: t = '{dx: OFF_NEG,  dy: OFF_ZERO, grp: G_HORIZ};
            4'd2: t = '{dx: OFF_POS,  dy: OFF_ZERO, grp: G_HORIZ};
            4'd3: t = '{dx: OFF_ZERO, dy: OFF_NEG,  grp: G_VERT};
            4'd4: t = '{dx: OFF_ZERO, dy: OFF_POS,  grp: G_VERT};
            4'd5: t = '{dx: OFF_NEG,  dy: OFF_NEG,  grp: G_DIAG};
            4'd6: t = '{dx: OFF_POS,  dy: OFF_NEG,  grp: G_DIAG};
            4'd7: t = '{dx: OFF_NEG,  dy: OFF_POS,  grp: G_DIAG};
            4'd8: t = '{dx: OFF_POS,  dy: OFF_POS,  grp: G_DIAG};
            default: t = '{dx: OFF_ZERO, dy: OFF_ZERO, grp: G_CENTER};
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

### design/bayer_bilinear_demosaic.sv
// Bilinear BGGR demosaic over a stored raw frame with an APB register port.
//
// Channel   Direction  Handshake                  Contents
// s stream  in         i_s_tvalid / o_s_tready    tdata: column, row, raw_sample; tuser: action
// m stream  out        o_m_tvalid / i_m_tready    tdata: red, green, blue; tuser: out_of_frame
// apb       in/out     psel, penable, pready      frame_width at 0x0, frame_height at 0x4
//
// A write transaction stores its byte as it is accepted. A read inside the frame
// fetches its neighbors from the single-port frame memory, one neighbor byte per
// cycle (5 at a green site, 9 at a red or blue site) and sums each registered
// read byte into its group; a read outside the frame goes straight to S_DONE.
// Reset is synchronous and active low; it clears control state and the registers,
// not the frame memory. A result waits in the output register while the next
// transaction is accepted; a new result waits in its final state until that
// register is free.
`default_nettype none
`include "bayer_bilinear_demosaic_assert.svh"
module bayer_bilinear_demosaic import bbd_pkg::*; #(
    parameter int MAX_WIDTH  = C_MAX_WIDTH,
    parameter int MAX_HEIGHT = C_MAX_HEIGHT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // column [8:0], row [16:9], raw_sample [24:17]
    input  wire logic        i_s_tuser,   // action [0]
    // Output stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic             o_m_tuser,   // out_of_frame [0]
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > C_CFG_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : C_CFG_WIDTH_W;
    localparam int HW  = ($clog2(MAX_HEIGHT + 1) > C_CFG_HEIGHT_W) ?
                         $clog2(MAX_HEIGHT + 1) : C_CFG_HEIGHT_W;
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_HEIGHT * (2 ** CW);

    // Registers.
    logic [C_CFG_WIDTH_W-1:0]  r_frame_width;
    logic [C_CFG_HEIGHT_W-1:0] r_frame_height;

    t_state                r_state, n_state;
    logic [C_STEP_W-1:0]   r_step, n_step;
    logic [CW-1:0]         r_x, n_x;
    logic [RW-1:0]         r_y, n_y;
    logic                  r_oof, n_oof;
    logic                  r_green_site, n_green_site;
    logic [C_PIX_W-1:0]    r_acc_c, n_acc_c;
    logic [C_PIX_W:0]      r_acc_h, n_acc_h;
    logic [C_PIX_W:0]      r_acc_v, n_acc_v;
    logic [C_PIX_W+1:0]    r_acc_d, n_acc_d;
    logic [C_PIX_W-1:0]    r_rd_data;
    logic                  r_out_valid, n_out_valid;
    logic [23:0]           r_out_data, n_out_data;
    logic                  r_out_oof, n_out_oof;

    logic [C_PIX_W-1:0]    r_mem [DEPTH];

    // Combinational signals.
    logic                  s_accept;
    logic                  cfg_write;
    logic [WW-1:0]         w_use, w_lim, col_ext, x_clamp;
    logic [HW-1:0]         h_use, h_lim, row_ext, y_clamp;
    logic                  in_frame, in_store;
    logic [AW-1:0]         wr_addr, tap_addr, mem_addr;
    logic                  mem_we;
    t_tap                  tap_issue, tap_acc;
    logic [CW-1:0]         tap_x;
    logic [RW-1:0]         tap_y;
    logic [C_STEP_W-1:0]   n_taps;
    logic [C_PIX_W+1:0]    add_a, add_sum;
    logic [C_PIX_W+1:0]    hv_sum;
    logic [C_PIX_W-1:0]    res_r, res_g, res_b;

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_oof;

    // Register read back.
    always_comb begin
        if (paddr[2] == REG_FRAME_HEIGHT) begin
            prdata = 32'(r_frame_height);
        end else begin
            prdata = 32'(r_frame_width);
        end
    end

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= C_WIDTH_RESET;
            r_frame_height <= C_HEIGHT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[C_CFG_WIDTH_W-1:0];
            end else begin
                r_frame_height <= pwdata[C_CFG_HEIGHT_W-1:0];
            end
        end
    end

    // Frame size in use, limited to the range the store supports.
    always_comb begin
        if (WW'(r_frame_width) < WW'(C_MIN_SIZE)) begin
            w_use = WW'(C_MIN_SIZE);
        end else if (WW'(r_frame_width) > WW'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(r_frame_width);
        end
        if (HW'(r_frame_height) < HW'(C_MIN_SIZE)) begin
            h_use = HW'(C_MIN_SIZE);
        end else if (HW'(r_frame_height) > HW'(MAX_HEIGHT)) begin
            h_use = HW'(MAX_HEIGHT);
        end else begin
            h_use = HW'(r_frame_height);
        end
    end

    // Incoming coordinate: bounds checks and clamping one pixel inside the edges.
    assign col_ext  = WW'(i_s_tdata[C_COL_W-1:0]);
    assign row_ext  = HW'(i_s_tdata[C_COL_W+C_ROW_W-1:C_COL_W]);
    assign w_lim    = w_use - WW'(2);
    assign h_lim    = h_use - HW'(2);
    assign in_frame = (col_ext < w_use) && (row_ext < h_use);
    assign in_store = (col_ext < WW'(MAX_WIDTH)) && (row_ext < HW'(MAX_HEIGHT));
    assign wr_addr  = {row_ext[RW-1:0], col_ext[CW-1:0]};

    always_comb begin
        if (col_ext == '0) begin
            x_clamp = WW'(1);
        end else if (col_ext > w_lim) begin
            x_clamp = w_lim;
        end else begin
            x_clamp = col_ext;
        end
        if (row_ext == '0) begin
            y_clamp = HW'(1);
        end else if (row_ext > h_lim) begin
            y_clamp = h_lim;
        end else begin
            y_clamp = row_ext;
        end
    end

    // Neighbor address for the fetch issued in this cycle.
    assign tap_issue = tap_info(r_step);
    assign tap_acc   = tap_info(r_step - C_STEP_W'(1));
    assign n_taps    = r_green_site ? C_TAPS_GREEN : C_TAPS_ALL;

    always_comb begin
        case (tap_issue.dx)
            OFF_NEG: tap_x = r_x - CW'(1);
            OFF_POS: tap_x = r_x + CW'(1);
            default: tap_x = r_x;
        endcase
        case (tap_issue.dy)
            OFF_NEG: tap_y = r_y - RW'(1);
            OFF_POS: tap_y = r_y + RW'(1);
            default: tap_y = r_y;
        endcase
    end

    assign tap_addr = {tap_y, tap_x};
    assign mem_addr = (r_state == S_READ) ? tap_addr : wr_addr;

    // Frame memory: one port, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_s_tdata[C_COL_W+C_ROW_W+C_PIX_W-1:C_COL_W+C_ROW_W];
        end
        r_rd_data <= r_mem[mem_addr];
    end

    // Shared adder: adds the returned byte into the sum of its neighbor group.
    always_comb begin
        case (tap_acc.grp)
            G_HORIZ: add_a = (C_PIX_W+2)'(r_acc_h);
            G_VERT:  add_a = (C_PIX_W+2)'(r_acc_v);
            G_DIAG:  add_a = r_acc_d;
            default: add_a = (C_PIX_W+2)'(r_acc_c);
        endcase
    end
    assign add_sum = add_a + (C_PIX_W+2)'(r_rd_data);

    // Color selection by site parity, each mean truncated.
    assign hv_sum = (C_PIX_W+2)'(r_acc_h) + (C_PIX_W+2)'(r_acc_v);

    always_comb begin
        if (r_y[0] && r_x[0]) begin
            res_r = r_acc_c;
            res_g = hv_sum[C_PIX_W+1:2];
            res_b = r_acc_d[C_PIX_W+1:2];
        end else if (r_y[0]) begin
            res_r = r_acc_h[C_PIX_W:1];
            res_g = r_acc_c;
            res_b = r_acc_v[C_PIX_W:1];
        end else if (r_x[0]) begin
            res_r = r_acc_v[C_PIX_W:1];
            res_g = r_acc_c;
            res_b = r_acc_h[C_PIX_W:1];
        end else begin
            res_r = r_acc_d[C_PIX_W+1:2];
            res_g = hv_sum[C_PIX_W+1:2];
            res_b = r_acc_c;
        end
    end

    // Sequencer: next state and datapath controls.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_x          = r_x;
        n_y          = r_y;
        n_oof        = r_oof;
        n_green_site = r_green_site;
        n_acc_c      = r_acc_c;
        n_acc_h      = r_acc_h;
        n_acc_v      = r_acc_v;
        n_acc_d      = r_acc_d;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_oof    = r_out_oof;
        mem_we       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == ACT_WRITE) begin
                        mem_we = in_store;
                    end else begin
                        n_oof        = !in_frame;
                        n_x          = x_clamp[CW-1:0];
                        n_y          = y_clamp[RW-1:0];
                        n_green_site = x_clamp[0] ^ y_clamp[0];
                        n_step       = '0;
                        n_acc_c      = '0;
                        n_acc_h      = '0;
                        n_acc_v      = '0;
                        n_acc_d      = '0;
                        n_state      = in_frame ? S_READ : S_DONE;
                    end
                end
            end
            S_READ: begin
                // Accumulate the byte fetched in the previous cycle.
                if (r_step != '0) begin
                    case (tap_acc.grp)
                        G_HORIZ: n_acc_h = add_sum[C_PIX_W:0];
                        G_VERT:  n_acc_v = add_sum[C_PIX_W:0];
                        G_DIAG:  n_acc_d = add_sum;
                        default: n_acc_c = add_sum[C_PIX_W-1:0];
                    endcase
                end
                if (r_step == n_taps) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + C_STEP_W'(1);
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_oof   = r_oof;
                    n_out_data  = r_oof ? 24'd0 : {res_b, res_g, res_r};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_x          <= n_x;
        r_y          <= n_y;
        r_oof        <= n_oof;
        r_green_site <= n_green_site;
        r_acc_c      <= n_acc_c;
        r_acc_h      <= n_acc_h;
        r_acc_v      <= n_acc_v;
        r_acc_d      <= n_acc_d;
        r_out_data   <= n_out_data;
        r_out_oof    <= n_out_oof;
    end

    // Checks on the sequencer and the result path.
    `BBD_ASSERT_IMP(a_step_bound, i_clk, i_rst_n, r_state == S_READ, r_step <= n_taps, "fetch counter ran past the tap count")
    `BBD_ASSERT_IMP(a_oof_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == 24'd0, "out-of-frame result carries nonzero color")
    `BBD_ASSERT_NXT(a_read_busy, i_clk, i_rst_n, s_accept && (i_s_tuser == ACT_READ), r_state != S_IDLE, "read transaction did not start the sequencer")
    `BBD_ASSERT_NXT(a_write_idle, i_clk, i_rst_n, s_accept && (i_s_tuser == ACT_WRITE), r_state == S_IDLE, "write transaction left the idle state")
    `BBD_ASSERT_NXT(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && !i_m_tready, (r_state == S_DONE) && o_m_tvalid, "result dropped while output stalled")

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the bilinear BGGR demosaic block.
`timescale 1ns / 100ps

module tb_top import bbd_pkg::*; ();

    localparam int C_IDLE_LIMIT = 2000;   // cycles without any transaction
    localparam int C_SETTLE     = 16;     // longer than the slowest read

    typedef struct packed {
        logic [C_PIX_W-1:0] red;
        logic [C_PIX_W-1:0] green;
        logic [C_PIX_W-1:0] blue;
        logic               out_of_frame;
    } t_pixel_result;

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;   // column [8:0], row [16:9], raw_sample [24:17]
    logic        i_s_tuser  = 1'b0; // action [0]
    logic        i_m_tready = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;         // red [7:0], green [15:8], blue [23:16]
    logic        o_m_tuser;         // out_of_frame [0]
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: the raw frame, which entries hold data, and the frame size.
    logic [C_PIX_W-1:0]        raw_img  [0:C_MAX_HEIGHT-1][0:C_MAX_WIDTH-1];
    bit                        raw_seen [0:C_MAX_HEIGHT-1][0:C_MAX_WIDTH-1];
    logic [C_CFG_WIDTH_W-1:0]  frame_w_cfg = C_WIDTH_RESET;
    logic [C_CFG_HEIGHT_W-1:0] frame_h_cfg = C_HEIGHT_RESET;
    t_pixel_result             rgb_expected [$];

    int errors = 0;
    int items_accepted = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_outside = 0;
    int n_sizes = 1;
    int idle_cycles = 0;

    // Sender burst state and receiver stall pattern state.
    int burst_left = 0;
    bit tx_steady = 1'b0;
    bit rx_force_ready = 1'b0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold = 0;
    bit rx_level = 1'b1;

    bayer_bilinear_demosaic i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Frame size in use after the register value is limited to the legal range.
    function automatic int size_in_use(input int value, input int top);
        if (value < C_MIN_SIZE) return C_MIN_SIZE;
        if (value > top) return top;
        return value;
    endfunction

    function automatic int frame_cols();
        return size_in_use(int'(frame_w_cfg), C_MAX_WIDTH);
    endfunction

    function automatic int frame_rows();
        return size_in_use(int'(frame_h_cfg), C_MAX_HEIGHT);
    endfunction

    // Pull a coordinate at least one pixel inside the frame edges.
    function automatic int inner_coord(input int v, input int n);
        if (v < 1) return 1;
        if (v > n - 2) return n - 2;
        return v;
    endfunction

    // Bilinear RGB value that a read at (col, row) must return.
    function automatic t_pixel_result demosaic_predict(input logic [C_COL_W-1:0] col,
                                                       input logic [C_ROW_W-1:0] row);
        t_pixel_result      res;
        int                 cols;
        int                 rows;
        int                 xx;
        int                 yy;
        logic [C_PIX_W-1:0] center;
        logic [8:0]         horiz;
        logic [8:0]         vert;
        logic [9:0]         diag;
        logic [9:0]         plus_sum;
        cols = frame_cols();
        rows = frame_rows();
        res = '{red: '0, green: '0, blue: '0, out_of_frame: 1'b1};
        if (int'(col) >= cols || int'(row) >= rows) return res;
        xx = inner_coord(int'(col), cols);
        yy = inner_coord(int'(row), rows);
        center   = raw_img[yy][xx];
        horiz    = 9'(raw_img[yy][xx-1]) + 9'(raw_img[yy][xx+1]);
        vert     = 9'(raw_img[yy-1][xx]) + 9'(raw_img[yy+1][xx]);
        diag     = 10'(raw_img[yy-1][xx-1]) + 10'(raw_img[yy-1][xx+1])
                 + 10'(raw_img[yy+1][xx-1]) + 10'(raw_img[yy+1][xx+1]);
        plus_sum = 10'(horiz) + 10'(vert);
        res.out_of_frame = 1'b0;
        // Site parity picks which colors are sampled directly.
        case ({yy[0], xx[0]})
            2'b11: begin
                res.red   = center;
                res.green = plus_sum[9:2];
                res.blue  = diag[9:2];
            end
            2'b10: begin
                res.red   = horiz[8:1];
                res.green = center;
                res.blue  = vert[8:1];
            end
            2'b01: begin
                res.red   = vert[8:1];
                res.green = center;
                res.blue  = horiz[8:1];
            end
            default: begin
                res.red   = diag[9:2];
                res.green = plus_sum[9:2];
                res.blue  = center;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Send one transaction on the input stream and update the predictor on acceptance.
    task automatic send_pixel_op(input logic act, input logic [C_COL_W-1:0] col,
                                 input logic [C_ROW_W-1:0] row,
                                 input logic [C_PIX_W-1:0] sample);
        if (!tx_steady && burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, sample, row, col};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        items_accepted++;
        if (burst_left > 0) burst_left--;
        if (act == ACT_WRITE) begin
            raw_img[row][col]  = sample;
            raw_seen[row][col] = 1'b1;
            n_writes++;
        end else begin
            rgb_expected.push_back(demosaic_predict(col, row));
            n_reads++;
            if (int'(col) >= frame_cols() || int'(row) >= frame_rows()) n_outside++;
        end
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rgb_expected.size() != 0) @(posedge i_clk);
    endtask

    // Write one register over APB, then read it back.
    task automatic program_register(input logic reg_idx, input logic [31:0] value);
        logic [31:0] readback_want;
        readback_want = (reg_idx == REG_FRAME_WIDTH) ? {22'd0, value[9:0]}
                                                     : {23'd0, value[8:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_FRAME_WIDTH) frame_w_cfg = value[C_CFG_WIDTH_W-1:0];
        else frame_h_cfg = value[C_CFG_HEIGHT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("register readback", readback_want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the frame size once the block has gone quiet.
    task automatic apply_frame_size(input logic [31:0] cols, input logic [31:0] rows);
        wait_results_drained();
        repeat (C_SETTLE) @(posedge i_clk);
        program_register(REG_FRAME_WIDTH, cols);
        program_register(REG_FRAME_HEIGHT, rows);
        n_sizes++;
    endtask

    // Coordinate biased toward the frame edges.
    function automatic int pick_coord(input int n);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return n - 2;
            3: return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    // Fill the 3x3 neighborhood of an in-frame site as needed, then read it.
    task automatic read_with_neighbors();
        int col;
        int row;
        int xx;
        int yy;
        int fill;
        logic [C_PIX_W-1:0] value;
        col  = pick_coord(frame_cols());
        row  = pick_coord(frame_rows());
        xx   = inner_coord(col, frame_cols());
        yy   = inner_coord(row, frame_rows());
        fill = $urandom_range(0, 7);
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                if (!raw_seen[yy+dy][xx+dx] || $urandom_range(0, 3) == 0) begin
                    value = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : 8'($urandom);
                    send_pixel_op(ACT_WRITE, 9'(xx + dx), 8'(yy + dy), value);
                end
            end
        end
        send_pixel_op(ACT_READ, 9'(col), 8'(row), 8'($urandom));
    endtask

    // Read beyond the frame in use, or store a stray byte when no such place exists.
    task automatic read_outside_or_write();
        int cols;
        int rows;
        cols = frame_cols();
        rows = frame_rows();
        if (cols < C_MAX_WIDTH && (rows == C_MAX_HEIGHT || $urandom_range(0, 1) == 0))
            send_pixel_op(ACT_READ, 9'($urandom_range(cols, C_MAX_WIDTH - 1)),
                          8'($urandom), 8'($urandom));
        else if (rows < C_MAX_HEIGHT)
            send_pixel_op(ACT_READ, 9'($urandom), 8'($urandom_range(rows, C_MAX_HEIGHT - 1)),
                          8'($urandom));
        else
            send_pixel_op(ACT_WRITE, 9'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Random traffic: mostly neighborhood fills followed by a read.
    task automatic run_random(input int n_items, input bit pause_midway);
        int start;
        int pick;
        bit paused;
        start  = items_accepted;
        paused = 1'b0;
        while (items_accepted - start < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) read_with_neighbors();
            else if (pick < 9) send_pixel_op(ACT_WRITE, 9'($urandom), 8'($urandom), 8'($urandom));
            else read_outside_or_write();
            if (pause_midway && !paused && items_accepted - start >= n_items / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Top-left corner at the reset size: every site parity, clamping and outside reads.
    task automatic test_directed_sites();
        logic [C_PIX_W-1:0] vals [0:15];
        vals = '{8'hFF, 8'h80, 8'hFF, 8'h13, 8'h7F, 8'h00, 8'hC1, 8'hFE,
                 8'hFF, 8'h3A, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'hE7, 8'h00};
        for (int i = 0; i < 16; i++)
            send_pixel_op(ACT_WRITE, 9'(i % 4), 8'(i / 4), vals[i]);
        send_pixel_op(ACT_READ, 9'd0, 8'd0, 8'hFF);
        send_pixel_op(ACT_READ, 9'd1, 8'd1, 8'h00);
        send_pixel_op(ACT_READ, 9'd2, 8'd1, 8'hFF);
        send_pixel_op(ACT_READ, 9'd1, 8'd2, 8'h00);
        send_pixel_op(ACT_READ, 9'd2, 8'd2, 8'hFF);
        send_pixel_op(ACT_READ, 9'd316, 8'd0, 8'h00);
        send_pixel_op(ACT_READ, 9'd0, 8'd208, 8'hFF);
        send_pixel_op(ACT_READ, 9'd511, 8'd255, 8'hFF);
    endtask

    // Random traffic at the reset size, with one full pause for the results.
    task automatic test_reset_size_random();
        run_random(70, 1'b1);
    endtask

    // Smallest and largest frames, including register values beyond the legal range.
    task automatic test_size_extremes();
        apply_frame_size(3, 3);
        run_random(50, 1'b0);
        apply_frame_size(512, 256);
        run_random(50, 1'b0);
        apply_frame_size(0, 0);
        run_random(50, 1'b0);
        apply_frame_size(1023, 511);
        run_random(50, 1'b0);
    endtask

    // Irregular frame sizes.
    task automatic test_odd_sizes();
        apply_frame_size(2, 255);
        run_random(40, 1'b0);
        for (int i = 0; i < 2; i++) begin
            apply_frame_size($urandom_range(3, 512), $urandom_range(3, 256));
            run_random(40, 1'b0);
        end
    endtask

    // Back-to-back transactions with the receiver always ready.
    task automatic test_steady_streams();
        wait_results_drained();
        tx_steady      = 1'b1;
        rx_force_ready = 1'b1;
        run_random(60, 1'b0);
        wait_results_drained();
        tx_steady      = 1'b0;
        rx_force_ready = 1'b0;
    endtask

    // Receiver stall pattern: a random mode, held for a random stretch before the next pick.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 200);
        end else begin
            rx_mode_left--;
        end
        if (rx_force_ready || rx_mode == 0) begin
            i_m_tready <= 1'b1;
        end else if (rx_mode == 1) begin
            i_m_tready <= 1'($urandom_range(0, 1));
        end else if (rx_mode == 2) begin
            i_m_tready <= ($urandom_range(0, 3) == 0);
        end else begin
            if (rx_hold == 0) begin
                rx_hold  = $urandom_range(1, 30);
                rx_level = ~rx_level;
            end else begin
                rx_hold--;
            end
            i_m_tready <= rx_level;
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pixel_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (rgb_expected.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                want = rgb_expected.pop_front();
                check_field("red", want.red, o_m_tdata[7:0]);
                check_field("green", want.green, o_m_tdata[15:8]);
                check_field("blue", want.blue, o_m_tdata[23:16]);
                check_field("out_of_frame", want.out_of_frame, o_m_tuser);
            end
        end
    end

    // Watchdog: end the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, rgb_expected.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sites();
        test_reset_size_random();
        test_size_extremes();
        test_odd_sizes();
        test_steady_streams();
        wait_results_drained();
        repeat (C_SETTLE) @(posedge i_clk);
        $display("Run covered %0d raw writes and %0d reads (%0d outside the frame)",
                 n_writes, n_reads, n_outside);
        $display("over %0d frame sizes, with random sender gaps and receiver stalls.", n_sizes);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/bbd_pkg.sv
design/bayer_bilinear_demosaic.sv
tb/sv/tb_top.sv
